>>> hw/rtl/bdtc_pkg.sv
// Shared constants, types and codes for the baseline deviation trigger capture block.
package bdtc_pkg;

   // Ring geometry; depth is a power of two so the pointers wrap on their own
   localparam int RING_DEPTH = 1024;
   localparam int PTR_W      = $clog2(RING_DEPTH);

   // Field widths
   localparam int SAMPLE_W   = 12;
   localparam int OFFSET_W   = 10;
   localparam int WSTART_W   = 10;
   localparam int THRESH_W   = 12;
   localparam int PRETRIG_W  = 10;
   localparam int COUNT_W    = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 12;

   // Learning: ten samples feed the baseline, eleven are stored
   localparam logic [COUNT_W-1:0] LEARN_SAMPLES = 4'd10;
   localparam logic [COUNT_W-1:0] STORED_LEARN  = 4'd11;

   // Divide by ten as a multiply by round(2^15 / 10) and a shift; exact for 12-bit input
   localparam int                DIV10_W     = 13;
   localparam logic [DIV10_W-1:0] DIV10_MUL   = 13'd3277;
   localparam int                DIV10_SHIFT = 15;

   // Register reset values
   localparam logic [THRESH_W-1:0]  THRESH_RESET  = 12'd20;
   localparam logic [PRETRIG_W-1:0] PRETRIG_RESET = 10'd20;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TRIG_THRESHOLD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRETRIG_LEN    = 1'b1;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_LEARN = 2'd1,
      PH_WAIT  = 2'd2,
      PH_TRIG  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      OP_ARM    = 2'd0,
      OP_SAMPLE = 2'd1,
      OP_READ   = 2'd2,
      OP_ABORT  = 2'd3
   } opcode_type;

   // Ring access issued for one transaction
   typedef struct packed {
      logic                we;
      logic [PTR_W-1:0]    waddr;
      logic [SAMPLE_W-1:0] wdata;
      logic                re;
      logic [PTR_W-1:0]    raddr;
   } ring_cmd_type;

   // Result fields known at accept time; read data joins from the registered ring read
   typedef struct packed {
      phase_type           phase;
      logic                trig_hit;
      logic [WSTART_W-1:0] window_start;
      logic [SAMPLE_W-1:0] baseline;
      logic                is_read;
   } step_result_type;

endpackage

>>> hw/rtl/bdtc_ctrl.sv
// Capture control: phase, learning counter, baseline, ring pointer and window base.
module bdtc_ctrl import bdtc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  opcode_type           opcode,
   input  logic [SAMPLE_W-1:0]  sample_value,
   input  logic [OFFSET_W-1:0]  read_offset,
   input  logic [THRESH_W-1:0]  trig_threshold,
   input  logic [PRETRIG_W-1:0] pretrig_len,
   output ring_cmd_type         ring_cmd,
   output step_result_type      result
);

   phase_type           phase_ff, phase_in;
   logic [PTR_W-1:0]    wp_ff, wp_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [SAMPLE_W-1:0] sum_ff, sum_in;
   logic [PTR_W-1:0]    wbase_ff, wbase_in;

   logic [SAMPLE_W+DIV10_W-1:0] div_prod;
   logic [SAMPLE_W-1:0]         div_quot;
   logic [SAMPLE_W-1:0]         deviation;
   logic [PTR_W-1:0]            wp_next;
   logic [COUNT_W-1:0]          count_next;
   logic                        hit;

   // Sample divided by ten, truncated
   assign div_prod = (SAMPLE_W+DIV10_W)'(sample_value) * (SAMPLE_W+DIV10_W)'(DIV10_MUL);
   assign div_quot = SAMPLE_W'(div_prod >> DIV10_SHIFT);

   // Absolute deviation from baseline
   assign deviation = (sample_value > sum_ff) ? (sample_value - sum_ff)
                                              : (sum_ff - sample_value);

   assign wp_next    = wp_ff + 1'b1;
   assign count_next = count_ff + 1'b1;

   // Next state, ring command and result for the offered transaction
   always_comb begin
      phase_in       = phase_ff;
      wp_in          = wp_ff;
      count_in       = count_ff;
      sum_in         = sum_ff;
      wbase_in       = wbase_ff;
      hit            = 1'b0;
      ring_cmd.we    = 1'b0;
      ring_cmd.waddr = wp_ff;
      ring_cmd.wdata = sample_value;
      ring_cmd.re    = 1'b0;
      ring_cmd.raddr = wbase_ff + PTR_W'(read_offset);
      unique case (opcode)
         OP_ARM: begin
            wp_in    = '0;
            count_in = '0;
            sum_in   = '0;
            phase_in = PH_LEARN;
         end
         OP_SAMPLE: begin
            if (phase_ff == PH_LEARN) begin
               ring_cmd.we = accept;
               wp_in       = wp_next;
               if (count_ff < LEARN_SAMPLES) begin
                  sum_in = sum_ff + div_quot;
               end
               count_in = count_next;
               if (count_next >= STORED_LEARN) begin
                  phase_in = PH_WAIT;
                  wp_in    = '0;
               end
            end else if (phase_ff == PH_WAIT) begin
               ring_cmd.we = accept;
               wp_in       = wp_next;
               if (deviation > trig_threshold) begin
                  hit      = 1'b1;
                  phase_in = PH_TRIG;
                  wbase_in = wp_next - PTR_W'(pretrig_len);
               end
            end
         end
         OP_READ: begin
            ring_cmd.re = accept;
         end
         OP_ABORT: begin
            phase_in = PH_IDLE;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
      result.phase        = phase_in;
      result.trig_hit     = hit;
      result.window_start = WSTART_W'(wbase_in);
      result.baseline     = sum_in;
      result.is_read      = (opcode == OP_READ);
   end

   // Advance state only on an accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         wp_ff    <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
         wbase_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         wp_ff    <= wp_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         wbase_ff <= wbase_in;
      end
   end

endmodule

>>> hw/rtl/baseline_deviation_trigger_capture.sv
// An accepted request passes the ring read register, then the output register, before its response.
// Throughput: one transaction per cycle while the response channel is not stalled; the ring has
// one write and one read port, each transaction uses at most one of them, and the read data is registered.
// A response waiting on the output does not block a new request until the ring stage fills.
// Reset (synchronous, active high) clears phase, pointer, count, baseline, window base and
// registers; the ring is not cleared and holds undefined data until written.
module baseline_deviation_trigger_capture import bdtc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,   // [11:0] sample_value, [21:12] read_offset
   input  logic [1:0]            req_tuser,   // [1:0] opcode
   // Response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [39:0]           rsp_tdata,   // [9:0] window_start, [21:10] read_data,
                                              // [33:22] baseline_out
   output logic [2:0]            rsp_tuser,   // [1:0] phase, [2] trig_hit
   // Configuration write port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [THRESH_W-1:0]  thresh_ff;
   logic [PRETRIG_W-1:0] pretrig_ff;

   logic [SAMPLE_W-1:0] ring [RING_DEPTH];
   logic [SAMPLE_W-1:0] ring_rdata_ff;

   ring_cmd_type    ring_cmd;
   step_result_type step_res;

   logic            req_accept;
   logic            s1_advance;
   logic            s1_valid_ff, s1_valid_in;
   step_result_type s1_res_ff;

   logic                out_valid_ff, out_valid_in;
   phase_type           out_phase_ff;
   logic                out_hit_ff;
   logic [WSTART_W-1:0] out_wstart_ff;
   logic [SAMPLE_W-1:0] out_rdata_ff;
   logic [SAMPLE_W-1:0] out_base_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff  <= THRESH_RESET;
         pretrig_ff <= PRETRIG_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TRIG_THRESHOLD: thresh_ff  <= THRESH_W'(csr_wdata);
            CSR_PRETRIG_LEN:    pretrig_ff <= PRETRIG_W'(csr_wdata);
            default:            thresh_ff  <= thresh_ff;
         endcase
      end
   end

   // Handshake: the ring stage moves on when the output register is free or drained
   assign s1_advance = !out_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_accept = req_tvalid && req_tready;

   bdtc_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .accept         (req_accept),
      .opcode         (opcode_type'(req_tuser)),
      .sample_value   (req_tdata[11:0]),
      .read_offset    (req_tdata[21:12]),
      .trig_threshold (thresh_ff),
      .pretrig_len    (pretrig_ff),
      .ring_cmd       (ring_cmd),
      .result         (step_res)
   );

   // Capture ring: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ring_cmd.we) begin
         ring[ring_cmd.waddr] <= ring_cmd.wdata;
      end
      if (ring_cmd.re) begin
         ring_rdata_ff <= ring[ring_cmd.raddr];
      end
   end

   // Ring stage valid
   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      out_valid_in = s1_advance ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold the accepted transaction's fields next to the ring read
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_res_ff <= step_res;
      end
   end

   // Load the output register; read data only for read transactions
   always_ff @(posedge clock) begin
      if (s1_advance && s1_valid_ff) begin
         out_phase_ff  <= s1_res_ff.phase;
         out_hit_ff    <= s1_res_ff.trig_hit;
         out_wstart_ff <= s1_res_ff.window_start;
         out_rdata_ff  <= s1_res_ff.is_read ? ring_rdata_ff : '0;
         out_base_ff   <= s1_res_ff.baseline;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_base_ff, out_rdata_ff, out_wstart_ff};
   assign rsp_tuser  = {out_hit_ff, out_phase_ff};

   // A trigger is reported only together with the triggered phase
   a_hit_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tuser[1:0] == PH_TRIG)
      else $error("trigger reported outside triggered phase");

   // One ring port per transaction
   a_ring_port: assert property (@(posedge clock) disable iff (reset)
      !(ring_cmd.we && ring_cmd.re))
      else $error("ring write and read in the same cycle");

   // A stalled ring stage must not take a new request, so its read data holds
   a_stall_no_accept: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance |-> !req_accept)
      else $error("request accepted while ring stage stalled");

   // A stalled ring stage keeps its transaction
   a_stall_keep: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance |=> s1_valid_ff && $stable(ring_rdata_ff))
      else $error("ring stage lost data during stall");

endmodule
